FILE: design/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg
// Widths, region codes and transaction types shared by the point to segment
// distance pipeline.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int CW   = 32;          // coordinate width
    localparam int WW   = CW + 1;      // point minus start
    localparam int EW   = CW + 2;      // point minus end
    localparam int PW   = WW + CW;     // cross product terms
    localparam int DLW  = 2 * CW;      // squared segment length
    localparam int QW   = 2 * CW + 4;  // squared distance
    localparam int RW   = QW / 2;      // distance
    localparam int CRW  = PW;          // magnitude of cross product
    localparam int LOW  = CW + 1;      // low split of cross magnitude
    localparam int HIW  = CRW - LOW;   // high split of cross magnitude
    localparam int NW   = 2 * CRW;     // dividend

    localparam logic [1:0] REGION_ON     = 2'd0;
    localparam logic [1:0] REGION_BEFORE = 2'd1;
    localparam logic [1:0] REGION_BEYOND = 2'd2;

    typedef struct packed {
        logic [NW-1:0]  num;
        logic [DLW-1:0] den;
        logic [1:0]     region;
        logic           degen;
    } t_div_in_s;

    typedef struct packed {
        logic [QW-1:0] sq;
        logic [1:0]    region;
        logic          degen;
    } t_root_in_s;

    typedef struct packed {
        logic [RW-1:0] distance;
        logic [1:0]    region;
        logic          degen;
    } t_result_s;

endpackage

FILE: design/psd_front.sv
// ----------------------------------------------------------------------------
// psd_front
// Six stage geometry front end: differences, products, dot and cross sums,
// region decision and the square of the cross product.
// ----------------------------------------------------------------------------
module psd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [psd_pkg::CW-1:0] i_point_x,
    input  logic signed [psd_pkg::CW-1:0] i_point_y,
    input  logic signed [psd_pkg::CW-1:0] i_seg_start_x,
    input  logic signed [psd_pkg::CW-1:0] i_seg_start_y,
    input  logic signed [psd_pkg::CW-1:0] i_seg_dir_x,
    input  logic signed [psd_pkg::CW-1:0] i_seg_dir_y,
    output logic                          o_valid,
    output psd_pkg::t_div_in_s            o_data
);

    localparam int WW  = psd_pkg::WW;
    localparam int EW  = psd_pkg::EW;
    localparam int PW  = psd_pkg::PW;
    localparam int DLW = psd_pkg::DLW;
    localparam int QW  = psd_pkg::QW;
    localparam int CW  = psd_pkg::CW;
    localparam int CRW = psd_pkg::CRW;
    localparam int LOW = psd_pkg::LOW;
    localparam int HIW = psd_pkg::HIW;
    localparam int NW  = psd_pkg::NW;

    logic [5:0] r_v;

    // stage 1
    logic signed [WW-1:0] r1_wx, r1_wy;
    logic signed [EW-1:0] r1_ex, r1_ey;
    logic signed [CW-1:0] r1_dx, r1_dy;
    // stage 2
    logic signed [PW-1:0]   r2_wxdx, r2_wydy, r2_wxdy, r2_wydx;
    logic signed [DLW-1:0]  r2_dxx, r2_dyy;
    logic signed [2*WW-1:0] r2_wxx, r2_wyy;
    logic signed [2*EW-1:0] r2_exx, r2_eyy;
    // stage 3
    logic signed [PW:0]     r3_dot, r3_cr;
    logic [DLW-1:0]         r3_dlen;
    logic [QW-1:0]          r3_nw, r3_ne;
    // stage 4
    logic [CRW-1:0]         r4_acr;
    logic [QW-1:0]          r4_num;
    logic [DLW-1:0]         r4_den;
    logic [1:0]             r4_region;
    logic                   r4_degen, r4_foot;
    // stage 5
    logic [2*HIW-1:0]       r5_hh;
    logic [HIW+LOW-1:0]     r5_hl;
    logic [2*LOW-1:0]       r5_ll;
    logic [QW-1:0]          r5_num;
    logic [DLW-1:0]         r5_den;
    logic [1:0]             r5_region;
    logic                   r5_degen, r5_foot;
    // stage 6
    psd_pkg::t_div_in_s     r6_data;

    logic                   n_degen, n_neg, n_gt, n_foot;
    logic [1:0]             n_region;
    logic [NW-1:0]          n_sq;

    always_comb begin
        n_degen = (r3_dlen == '0);
        n_neg   = r3_dot[PW];
        n_gt    = (r3_dot[PW-1:0] > PW'(r3_dlen));
        n_foot  = !n_degen && !n_neg && !n_gt;
        if (n_degen || n_neg) begin
            n_region = psd_pkg::REGION_BEFORE;
        end else if (n_gt) begin
            n_region = psd_pkg::REGION_BEYOND;
        end else begin
            n_region = psd_pkg::REGION_ON;
        end
        n_sq = (NW'(r5_hh) << (2 * LOW)) + (NW'(r5_hl) << (LOW + 1)) + NW'(r5_ll);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_wx <= WW'(i_point_x) - WW'(i_seg_start_x);
            r1_wy <= WW'(i_point_y) - WW'(i_seg_start_y);
            r1_ex <= EW'(i_point_x) - EW'(i_seg_start_x) - EW'(i_seg_dir_x);
            r1_ey <= EW'(i_point_y) - EW'(i_seg_start_y) - EW'(i_seg_dir_y);
            r1_dx <= i_seg_dir_x;
            r1_dy <= i_seg_dir_y;

            r2_wxdx <= PW'(r1_wx) * PW'(r1_dx);
            r2_wydy <= PW'(r1_wy) * PW'(r1_dy);
            r2_wxdy <= PW'(r1_wx) * PW'(r1_dy);
            r2_wydx <= PW'(r1_wy) * PW'(r1_dx);
            r2_dxx  <= DLW'(r1_dx) * DLW'(r1_dx);
            r2_dyy  <= DLW'(r1_dy) * DLW'(r1_dy);
            r2_wxx  <= (2*WW)'(r1_wx) * (2*WW)'(r1_wx);
            r2_wyy  <= (2*WW)'(r1_wy) * (2*WW)'(r1_wy);
            r2_exx  <= (2*EW)'(r1_ex) * (2*EW)'(r1_ex);
            r2_eyy  <= (2*EW)'(r1_ey) * (2*EW)'(r1_ey);

            r3_dot  <= (PW+1)'(r2_wxdx) + (PW+1)'(r2_wydy);
            r3_cr   <= (PW+1)'(r2_wxdy) - (PW+1)'(r2_wydx);
            r3_dlen <= unsigned'(r2_dxx) + unsigned'(r2_dyy);
            r3_nw   <= QW'(unsigned'(r2_wxx)) + QW'(unsigned'(r2_wyy));
            r3_ne   <= QW'(unsigned'(r2_exx)) + QW'(unsigned'(r2_eyy));

            r4_acr    <= r3_cr[PW] ? CRW'(-r3_cr) : r3_cr[CRW-1:0];
            r4_num    <= (n_region == psd_pkg::REGION_BEYOND) ? r3_ne : r3_nw;
            r4_den    <= n_foot ? r3_dlen : DLW'(1);
            r4_region <= n_region;
            r4_degen  <= n_degen;
            r4_foot   <= n_foot;

            r5_hh     <= (2*HIW)'(r4_acr[CRW-1:LOW]) * (2*HIW)'(r4_acr[CRW-1:LOW]);
            r5_hl     <= (HIW+LOW)'(r4_acr[CRW-1:LOW]) * (HIW+LOW)'(r4_acr[LOW-1:0]);
            r5_ll     <= (2*LOW)'(r4_acr[LOW-1:0]) * (2*LOW)'(r4_acr[LOW-1:0]);
            r5_num    <= r4_num;
            r5_den    <= r4_den;
            r5_region <= r4_region;
            r5_degen  <= r4_degen;
            r5_foot   <= r4_foot;

            r6_data.num    <= r5_foot ? n_sq : NW'(r5_num);
            r6_data.den    <= r5_den;
            r6_data.region <= r5_region;
            r6_data.degen  <= r5_degen;
        end
    end

    assign o_valid = r_v[5];
    assign o_data  = r6_data;

endmodule

FILE: design/psd_div.sv
// ----------------------------------------------------------------------------
// psd_div
// Restoring divider, one quotient bit per pipeline stage: squared distance
// as the integer quotient of the dividend by the squared segment length.
// ----------------------------------------------------------------------------
module psd_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  psd_pkg::t_div_in_s  i_data,
    output logic                o_valid,
    output psd_pkg::t_root_in_s o_data
);

    localparam int QW  = psd_pkg::QW;
    localparam int DLW = psd_pkg::DLW;
    localparam int NW  = psd_pkg::NW;

    logic [QW-1:0]  r_v;
    logic [DLW-1:0] r_rem    [QW];
    logic [QW-1:0]  r_lq     [QW];
    logic [DLW-1:0] r_den    [QW];
    logic [1:0]     r_region [QW];
    logic           r_degen  [QW];

    logic           c_v      [QW+1];
    logic [DLW-1:0] c_rem    [QW+1];
    logic [QW-1:0]  c_lq     [QW+1];
    logic [DLW-1:0] c_den    [QW+1];
    logic [1:0]     c_region [QW+1];
    logic           c_degen  [QW+1];

    assign c_v[0]      = i_valid;
    assign c_rem[0]    = DLW'(i_data.num[NW-1:QW]);
    assign c_lq[0]     = i_data.num[QW-1:0];
    assign c_den[0]    = i_data.den;
    assign c_region[0] = i_data.region;
    assign c_degen[0]  = i_data.degen;

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DLW:0] w_t;
        logic [DLW:0] w_diff;
        logic         w_ge;

        assign w_t    = {c_rem[k], c_lq[k][QW-1]};
        assign w_diff = w_t - {1'b0, c_den[k]};
        assign w_ge   = (w_t >= {1'b0, c_den[k]});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]    <= w_ge ? w_diff[DLW-1:0] : w_t[DLW-1:0];
                r_lq[k]     <= {c_lq[k][QW-2:0], w_ge};
                r_den[k]    <= c_den[k];
                r_region[k] <= c_region[k];
                r_degen[k]  <= c_degen[k];
            end
        end

        assign c_v[k+1]      = r_v[k];
        assign c_rem[k+1]    = r_rem[k];
        assign c_lq[k+1]     = r_lq[k];
        assign c_den[k+1]    = r_den[k];
        assign c_region[k+1] = r_region[k];
        assign c_degen[k+1]  = r_degen[k];
    end

    assign o_valid       = c_v[QW];
    assign o_data.sq     = c_lq[QW];
    assign o_data.region = c_region[QW];
    assign o_data.degen  = c_degen[QW];

endmodule

FILE: design/psd_sqrt.sv
// ----------------------------------------------------------------------------
// psd_sqrt
// Digit by digit integer square root, one result bit per pipeline stage.
// ----------------------------------------------------------------------------
module psd_sqrt (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  psd_pkg::t_root_in_s i_data,
    output logic                o_valid,
    output psd_pkg::t_result_s  o_data
);

    localparam int QW = psd_pkg::QW;
    localparam int RW = psd_pkg::RW;

    logic [RW-1:0] r_v;
    logic [RW+1:0] r_rem    [RW];
    logic [RW-1:0] r_root   [RW];
    logic [QW-1:0] r_op     [RW];
    logic [1:0]    r_region [RW];
    logic          r_degen  [RW];

    logic          c_v      [RW+1];
    logic [RW+1:0] c_rem    [RW+1];
    logic [RW-1:0] c_root   [RW+1];
    logic [QW-1:0] c_op     [RW+1];
    logic [1:0]    c_region [RW+1];
    logic          c_degen  [RW+1];

    assign c_v[0]      = i_valid;
    assign c_rem[0]    = '0;
    assign c_root[0]   = '0;
    assign c_op[0]     = i_data.sq;
    assign c_region[0] = i_data.region;
    assign c_degen[0]  = i_data.degen;

    for (genvar k = 0; k < RW; k++) begin : g_stage
        logic [RW+3:0] w_t;
        logic [RW+3:0] w_trial;
        logic [RW+3:0] w_diff;
        logic          w_ge;

        assign w_t     = {c_rem[k], c_op[k][QW-1:QW-2]};
        assign w_trial = (RW+4)'({c_root[k], 2'b01});
        assign w_diff  = w_t - w_trial;
        assign w_ge    = (w_t >= w_trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= c_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]    <= w_ge ? w_diff[RW+1:0] : w_t[RW+1:0];
                r_root[k]   <= {c_root[k][RW-2:0], w_ge};
                r_op[k]     <= {c_op[k][QW-3:0], 2'b00};
                r_region[k] <= c_region[k];
                r_degen[k]  <= c_degen[k];
            end
        end

        assign c_v[k+1]      = r_v[k];
        assign c_rem[k+1]    = r_rem[k];
        assign c_root[k+1]   = r_root[k];
        assign c_op[k+1]     = r_op[k];
        assign c_region[k+1] = r_region[k];
        assign c_degen[k+1]  = r_degen[k];
    end

    assign o_valid         = c_v[RW];
    assign o_data.distance = c_root[RW];
    assign o_data.region   = c_region[RW];
    assign o_data.degen    = c_degen[RW];

endmodule

FILE: design/point_segment_distance_core.sv
// ----------------------------------------------------------------------------
// point_segment_distance_core
// Distance from a point to a 2D segment in signed Q16.16, exact and floored.
// ----------------------------------------------------------------------------
// input channel: i_valid / o_ready, one query per transaction (point, segment
// start and segment vector). output channel: o_valid / i_ready, one result per
// transaction (distance, region, degenerate flag), in query order.
// throughput: one transaction per cycle, sustained while the receiver keeps i_ready high.
// path from accept to o_valid: 6 geometry stages, 68 divider stages at one
// quotient bit each, 34 root stages at one result bit each, and the output
// register. the divider stages make up most of this path.
// the whole pipeline moves on one enable; a two entry output buffer holds
// results, so with the receiver stalled one more result is still taken while
// a result waits, after which o_ready drops until the receiver takes one.
// reset: synchronous, active low; clears all valid bits and the output
// buffer, no result is shown after reset until a new query has passed.
// zero-length segment: degenerate set, region before start, distance to start.
// ----------------------------------------------------------------------------
module point_segment_distance_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [psd_pkg::CW-1:0] i_point_x,
    input  logic signed [psd_pkg::CW-1:0] i_point_y,
    input  logic signed [psd_pkg::CW-1:0] i_seg_start_x,
    input  logic signed [psd_pkg::CW-1:0] i_seg_start_y,
    input  logic signed [psd_pkg::CW-1:0] i_seg_dir_x,
    input  logic signed [psd_pkg::CW-1:0] i_seg_dir_y,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [psd_pkg::RW-1:0]        o_distance,
    output logic [1:0]                    o_region,
    output logic                          o_degenerate
);

    logic                 w_en;
    logic                 w_front_v, w_div_v, w_root_v;
    psd_pkg::t_div_in_s   w_front_d;
    psd_pkg::t_root_in_s  w_div_d;
    psd_pkg::t_result_s   w_root_d;
    logic                 w_push, w_pop;

    logic                 r_main_v, r_spare_v;
    psd_pkg::t_result_s   r_main, r_spare;

    assign w_en    = !r_spare_v;
    assign o_ready = w_en;

    psd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (i_valid),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_seg_start_x (i_seg_start_x),
        .i_seg_start_y (i_seg_start_y),
        .i_seg_dir_x   (i_seg_dir_x),
        .i_seg_dir_y   (i_seg_dir_y),
        .o_valid       (w_front_v),
        .o_data        (w_front_d)
    );

    psd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_front_v),
        .i_data  (w_front_d),
        .o_valid (w_div_v),
        .o_data  (w_div_d)
    );

    psd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_div_v),
        .i_data  (w_div_d),
        .o_valid (w_root_v),
        .o_data  (w_root_d)
    );

    assign w_push = w_en && w_root_v;
    assign w_pop  = r_main_v && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v  <= 1'b0;
            r_spare_v <= 1'b0;
        end else if (r_spare_v) begin
            if (w_pop) begin
                r_spare_v <= 1'b0;
            end
        end else if (w_push) begin
            if (r_main_v && !w_pop) begin
                r_spare_v <= 1'b1;
            end else begin
                r_main_v <= 1'b1;
            end
        end else if (w_pop) begin
            r_main_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_spare_v) begin
            if (w_pop) begin
                r_main <= r_spare;
            end
        end else if (w_push) begin
            if (r_main_v && !w_pop) begin
                r_spare <= w_root_d;
            end else begin
                r_main <= w_root_d;
            end
        end
    end

    assign o_valid      = r_main_v;
    assign o_distance   = r_main.distance;
    assign o_region     = r_main.region;
    assign o_degenerate = r_main.degen;

`ifndef SYNTH
    a_spare_needs_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spare_v |-> r_main_v)
        else $error("spare result held without a main result");

    a_full_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_spare_v |-> !o_ready)
        else $error("input taken while output buffer full");

    a_degen_region: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_degenerate |-> o_region == psd_pkg::REGION_BEFORE)
        else $error("degenerate segment with wrong region");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result shown right after reset");
`endif

endmodule
